// ===== rtl/cgme_pkg.sv =====
// ----------------------------------------------------------------------------
// cgme_pkg - shared types and constants of the cluster graph merge engine
// Edge word layout, node word layout, command, class and status codes.
// ----------------------------------------------------------------------------
package cgme_pkg;

	localparam int NODES   = 64;
	localparam int NODE_W  = $clog2(NODES);
	localparam int EDGE_AW = 2 * NODE_W;
	localparam int EDGES   = NODES * NODES;

	localparam logic [2:0] CMD_INIT_NODE = 3'd0;
	localparam logic [2:0] CMD_INIT_EDGE = 3'd1;
	localparam logic [2:0] CMD_MERGE     = 3'd2;
	localparam logic [2:0] CMD_FORBID    = 3'd3;
	localparam logic [2:0] CMD_READ      = 3'd4;

	localparam logic [1:0] CL_FIN   = 2'd0;
	localparam logic [1:0] CL_PINF  = 2'd1;
	localparam logic [1:0] CL_NINF  = 2'd2;
	localparam logic [1:0] CL_UNDEF = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_INVIS = 2'd1;
	localparam logic [1:0] ST_FIXED = 2'd2;
	localparam logic [1:0] ST_SELF  = 2'd3;

	localparam int FL_VIS  = 0;
	localparam int FL_PERM = 1;
	localparam int FL_FORB = 2;

	typedef struct packed {
		logic signed [31:0] weight;
		logic [1:0]         cls;
		logic [2:0]         flags;
	} edge_t;

	typedef struct packed {
		logic              vis;
		logic [NODE_W-1:0] label;
	} node_t;

	localparam int EDGE_WW = $bits(edge_t);
	localparam int NODE_WW = $bits(node_t);

	// matrix is symmetric: lower index selects the row
	function automatic logic [EDGE_AW-1:0] eidx(input logic [NODE_W-1:0] x,
						   input logic [NODE_W-1:0] y);
		logic [NODE_W-1:0] lo;
		logic [NODE_W-1:0] hi;
		lo = (x < y) ? x : y;
		hi = (x < y) ? y : x;
		return {lo, hi};
	endfunction

endpackage

// ===== rtl/cluster_graph_merge_engine_unit.sv =====
// ----------------------------------------------------------------------------
// cluster_graph_merge_engine_unit - edge weight matrix with vertex contraction
// Symmetric edge matrix in RAM; init, merge, forbid and read commands.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | beat
//  --------+--------------------+-----------------------------------------
//  in      | in_valid/in_stall  | command, node_a, node_b, weight_in, marks
//  out     | out_valid/out_stall| status, edge fields, cluster, dirty, ovf
//
// Init/forbid/read pass S_RDA, S_RDB, S_CHK and S_FIN from accept to the
// result register, then return to S_IDLE before the next accept.
// A merge runs two sweeps over all nodes (the single edge RAM read port
// fetches u-a and u-b in turn); sweep 1 aborts on an invisible side edge.
// Reset: a clearing pass writes all EDGES edge entries (and the NODES node
// entries) to zero, with in_stall held high.
// One beat is worked at a time; the result register lets the next beat in
// while the previous result is still stalled.
//
module cluster_graph_merge_engine_unit import cgme_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         command,
	input  logic [NODE_W-1:0]  node_a,
	input  logic [NODE_W-1:0]  node_b,
	input  logic signed [31:0] weight_in,
	input  logic               mark_permanent,
	input  logic               mark_forbidden,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] weight_out,
	output logic [1:0]         weight_class,
	output logic               permanent_out,
	output logic               forbidden_out,
	output logic [NODE_W-1:0]  cluster_of_a,
	output logic               dirty,
	output logic               overflow
);

	typedef enum logic [11:0] {
		S_CLR  = 12'b0000_0000_0001,
		S_IDLE = 12'b0000_0000_0010,
		S_RDA  = 12'b0000_0000_0100,
		S_RDB  = 12'b0000_0000_1000,
		S_CHK  = 12'b0000_0001_0000,
		S_M1A  = 12'b0000_0010_0000,
		S_M1B  = 12'b0000_0100_0000,
		S_M1C  = 12'b0000_1000_0000,
		S_M2A  = 12'b0001_0000_0000,
		S_M2B  = 12'b0010_0000_0000,
		S_M2C  = 12'b0100_0000_0000,
		S_FIN  = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	// latched command
	logic [2:0]         cmd_q;
	logic [NODE_W-1:0]  a_q, b_q;
	logic signed [31:0] win_q;
	logic               mp_q, mf_q;

	logic [EDGE_AW-1:0] clr_q;
	logic [NODE_W-1:0]  u_q;
	node_t              na_q;
	edge_t              eab_q, ua_q;
	logic               dirty_q, ovf_q;

	// result staging
	logic [1:0]         res_status_q;
	logic               res_rep_q;
	edge_t              res_edge_q;
	logic [NODE_W-1:0]  res_label_q;

	// output register
	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic signed [31:0] out_weight_q;
	logic [1:0]         out_class_q;
	logic               out_perm_q, out_forb_q;
	logic [NODE_W-1:0]  out_label_q;
	logic               out_dirty_q, out_ovf_q;

	// RAM ports
	logic               edge_we, node_we;
	logic [EDGE_AW-1:0] edge_waddr, edge_raddr;
	logic [NODE_W-1:0]  node_waddr, node_raddr;
	edge_t              edge_wdata, edge_rdata;
	node_t              node_wdata, node_rdata;

	cgme_ram #(.WIDTH(EDGE_WW), .DEPTH(EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_waddr),
		.wdata (edge_wdata),
		.raddr (edge_raddr),
		.rdata (edge_rdata)
	);

	cgme_ram #(.WIDTH(NODE_WW), .DEPTH(NODES)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	// sum of side edges u-a (latched) and u-b (RAM output)
	logic [1:0]         sum_cls;
	logic signed [31:0] sum_w;
	logic               sum_ovf;

	cgme_wadd u_wadd (
		.x      (ua_q),
		.y      (edge_rdata),
		.cls    (sum_cls),
		.weight (sum_w),
		.ovf    (sum_ovf)
	);

	logic               in_acc, out_acc;
	logic [NODE_W-1:0]  u_nx;
	logic               u_last, skip_u;
	logic               self_loop, chk_invis, chk_fixed;
	edge_t              ie_word, fb_word, mg_word;
	logic [1:0]         chk_status;
	edge_t              chk_edge;
	logic [NODE_W-1:0]  chk_label;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;
	assign in_stall = (state_q != S_IDLE);

	assign u_nx      = u_q + NODE_W'(1);
	assign u_last    = (u_q == NODE_W'(NODES - 1));
	// other node u only takes part when it is visible and not a or b
	assign skip_u    = (u_q == a_q) || (u_q == b_q) || !node_rdata.vis;
	assign self_loop = (a_q == b_q);
	// in S_CHK the node RAM shows node b
	assign chk_invis = !na_q.vis || !node_rdata.vis || !eab_q.flags[FL_VIS];
	assign chk_fixed = eab_q.flags[FL_PERM] || eab_q.flags[FL_FORB];

	always_comb begin
		ie_word        = '0;
		ie_word.weight = win_q;
		ie_word.cls    = CL_FIN;
		ie_word.flags[FL_VIS] = 1'b1;
		if (mf_q) begin
			ie_word.flags[FL_FORB] = 1'b1;
			ie_word.cls    = CL_NINF;
			ie_word.weight = '0;
		end
		if (mp_q) begin
			ie_word.flags[FL_PERM] = 1'b1;
			ie_word.cls    = CL_PINF;
			ie_word.weight = '0;
		end

		fb_word        = eab_q;
		fb_word.flags[FL_FORB] = 1'b1;
		fb_word.cls    = CL_NINF;
		fb_word.weight = '0;

		mg_word        = ua_q;
		mg_word.cls    = sum_cls;
		mg_word.weight = sum_w;
		if (sum_cls == CL_PINF) begin
			mg_word.flags[FL_PERM] = 1'b1;
		end
		if (sum_cls == CL_NINF) begin
			mg_word.flags[FL_FORB] = 1'b1;
		end
	end

	// status, reported edge and label decided in S_CHK
	always_comb begin
		chk_status = ST_OK;
		chk_edge   = eab_q;
		chk_label  = na_q.label;
		case (cmd_q) inside
			CMD_INIT_NODE: chk_label = a_q;
			CMD_INIT_EDGE: begin
				chk_edge = ie_word;
				if (self_loop) begin
					chk_status = ST_SELF;
				end
			end
			CMD_MERGE, CMD_FORBID: begin
				if (cmd_q == CMD_FORBID) begin
					chk_edge = fb_word;
				end
				if (self_loop) begin
					chk_status = ST_SELF;
				end else if (chk_invis) begin
					chk_status = ST_INVIS;
				end else if (chk_fixed) begin
					chk_status = ST_FIXED;
				end
			end
			CMD_READ: begin
				if (self_loop) begin
					chk_status = ST_SELF;
				end else if (chk_invis) begin
					chk_status = ST_INVIS;
				end
			end
			default: ;
		endcase
	end

	// read addresses follow the sweep; a C state already fetches u+1
	always_comb begin
		edge_raddr = eidx(a_q, b_q);
		node_raddr = a_q;
		unique case (state_q) inside
			S_RDB, S_CHK: begin
				node_raddr = b_q;
			end
			S_M1A, S_M2A: begin
				node_raddr = u_q;
				edge_raddr = eidx(u_q, a_q);
			end
			S_M1B, S_M2B: begin
				node_raddr = u_q;
				edge_raddr = eidx(u_q, b_q);
			end
			S_M1C, S_M2C: begin
				node_raddr = u_nx;
				edge_raddr = eidx(u_nx, a_q);
			end
			default: begin
				node_raddr = a_q;
			end
		endcase
	end

	// writes and next state
	always_comb begin
		state_d    = state_q;
		edge_we    = 1'b0;
		edge_waddr = eidx(a_q, b_q);
		edge_wdata = ie_word;
		node_we    = 1'b0;
		node_waddr = a_q;
		node_wdata = '{vis: 1'b1, label: a_q};
		unique case (state_q)
			S_CLR: begin
				edge_we    = 1'b1;
				edge_waddr = clr_q;
				edge_wdata = '0;
				node_we    = 1'b1;
				node_waddr = clr_q[NODE_W-1:0];
				node_wdata = '0;
				if (clr_q == EDGE_AW'(EDGES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_acc) begin
					state_d = S_RDA;
				end
			end
			S_RDA: state_d = S_RDB;
			S_RDB: state_d = S_CHK;
			S_CHK: begin
				state_d = S_FIN;
				case (cmd_q)
					CMD_INIT_NODE: node_we = 1'b1;
					CMD_INIT_EDGE: edge_we = !self_loop;
					CMD_FORBID: begin
						edge_wdata = fb_word;
						edge_we    = !self_loop && !chk_invis && !chk_fixed;
					end
					CMD_MERGE: begin
						if (!self_loop && !chk_invis && !chk_fixed) begin
							state_d = S_M1A;
						end
					end
					default: ;
				endcase
			end
			S_M1A: state_d = S_M1B;
			S_M1B: state_d = S_M1C;
			S_M1C: begin
				if (!skip_u && (!ua_q.flags[FL_VIS] || !edge_rdata.flags[FL_VIS])) begin
					state_d = S_FIN;
				end else if (u_last) begin
					state_d = S_M2A;
				end else begin
					state_d = S_M1B;
				end
			end
			S_M2A: state_d = S_M2B;
			S_M2B: state_d = S_M2C;
			S_M2C: begin
				edge_waddr = eidx(u_q, a_q);
				edge_wdata = mg_word;
				edge_we    = !skip_u;
				// relabel members of b; b itself is hidden
				node_waddr = u_q;
				node_we    = (node_rdata.label == b_q) || (u_q == b_q);
				node_wdata.vis   = node_rdata.vis && (u_q != b_q);
				node_wdata.label = (node_rdata.label == b_q) ? a_q : node_rdata.label;
				state_d = u_last ? S_FIN : S_M2B;
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			dirty_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + EDGE_AW'(1);
			end
			if (state_q == S_CHK && cmd_q == CMD_FORBID && edge_we) begin
				dirty_q <= 1'b1;
			end
			if (state_q == S_M1C && u_last && state_d == S_M2A) begin
				dirty_q <= 1'b1;
			end
			if (state_q == S_FIN && state_d == S_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= command;
			a_q   <= node_a;
			b_q   <= node_b;
			win_q <= weight_in;
			mp_q  <= mark_permanent;
			mf_q  <= mark_forbidden;
			ovf_q <= 1'b0;
		end
		if (state_q == S_RDB) begin
			na_q  <= node_rdata;
			eab_q <= edge_rdata;
		end
		if (state_q == S_M1B || state_q == S_M2B) begin
			ua_q <= edge_rdata;
		end
		if (state_q == S_CHK || state_q == S_M1A || state_q == S_M2A) begin
			u_q <= '0;
		end else if (state_q == S_M1C || state_q == S_M2C) begin
			u_q <= u_nx;
		end
		if (state_q == S_M2C && !skip_u && sum_ovf) begin
			ovf_q <= 1'b1;
		end

		if (state_q == S_CHK) begin
			res_label_q  <= chk_label;
			res_edge_q   <= chk_edge;
			res_rep_q    <= !self_loop && (cmd_q <= CMD_READ);
			res_status_q <= chk_status;
		end
		if (state_q == S_M1C && state_d == S_FIN) begin
			res_status_q <= ST_INVIS;
		end
		if (state_q == S_M2C && u_last && na_q.label == b_q) begin
			res_label_q <= a_q;
		end

		if (state_q == S_FIN && state_d == S_IDLE) begin
			out_status_q <= res_status_q;
			out_label_q  <= res_label_q;
			out_dirty_q  <= dirty_q;
			out_ovf_q    <= ovf_q;
			if (res_rep_q && res_status_q == ST_OK) begin
				out_weight_q <= (res_edge_q.cls == CL_FIN) ? res_edge_q.weight : '0;
				out_class_q  <= res_edge_q.cls;
				out_perm_q   <= res_edge_q.flags[FL_PERM];
				out_forb_q   <= res_edge_q.flags[FL_FORB];
			end else begin
				out_weight_q <= '0;
				out_class_q  <= CL_FIN;
				out_perm_q   <= 1'b0;
				out_forb_q   <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign weight_out    = out_weight_q;
	assign weight_class  = out_class_q;
	assign permanent_out = out_perm_q;
	assign forbidden_out = out_forb_q;
	assign cluster_of_a  = out_label_q;
	assign dirty         = out_dirty_q;
	assign overflow      = out_ovf_q;

`ifndef ASSERT_OFF
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> in_stall)
		else $error("beat accepted during clearing pass");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!edge_we && !node_we))
		else $error("RAM written while idle");

	a_ovf_merge_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && ovf_q) |-> (cmd_q == CMD_MERGE))
		else $error("overflow raised outside a merge");

	a_result_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_FIN))
		else $error("result loaded outside finish state");
`endif

endmodule

// ===== rtl/cgme_ram.sv =====
// ----------------------------------------------------------------------------
// cgme_ram - generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cgme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/cgme_wadd.sv =====
// ----------------------------------------------------------------------------
// cgme_wadd - edge weight adder
// Class-aware sum of edge words x and y, Q16.16 saturating.
// ----------------------------------------------------------------------------
module cgme_wadd import cgme_pkg::*; (
	input  edge_t              x,
	input  edge_t              y,
	output logic [1:0]         cls,
	output logic signed [31:0] weight,
	output logic               ovf
);

	logic signed [32:0] sum;

	always_comb begin
		sum    = 33'(x.weight) + 33'(y.weight);
		weight = '0;
		ovf    = 1'b0;
		if (x.cls == CL_UNDEF || y.cls == CL_UNDEF ||
		    (x.cls == CL_PINF && y.cls == CL_NINF) ||
		    (x.cls == CL_NINF && y.cls == CL_PINF)) begin
			cls = CL_UNDEF;
		end else if (x.cls == CL_PINF || y.cls == CL_PINF) begin
			cls = CL_PINF;
		end else if (x.cls == CL_NINF || y.cls == CL_NINF) begin
			cls = CL_NINF;
		end else begin
			cls = CL_FIN;
			if (sum[32] != sum[31]) begin
				ovf    = 1'b1;
				weight = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
			end else begin
				weight = sum[31:0];
			end
		end
	end

endmodule
